// ===== rtl/bmf_pkg.sv =====
// Box mean filter: shared types, register indexes and back-end states.
// No dependencies; every other file but bmf_ram imports it.
package bmf_pkg;

	localparam int WIDTH_BITS  = 13;
	localparam int HEIGHT_BITS = 12;
	localparam int RADIUS_BITS = 4;
	localparam int SPAN_BITS   = 5;
	localparam int AREA_BITS   = 10;
	localparam int SUM_BITS    = 18;
	localparam int SLOT_BITS   = 5;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_SPARE  = 2'd3
	} reg_index_t;

	// effective (clamped) frame settings
	typedef struct packed {
		logic [WIDTH_BITS-1:0]  width;
		logic [HEIGHT_BITS-1:0] height;
		logic [RADIUS_BITS-1:0] radius;
		logic [SPAN_BITS-1:0]   span;
		logic [AREA_BITS-1:0]   area;
	} frame_cfg_t;

	// one result to compute: centre position and its row slot
	typedef struct packed {
		logic [HEIGHT_BITS-1:0] row;
		logic [WIDTH_BITS-1:0]  col;
		logic [SLOT_BITS-1:0]   slot;
		logic                   last;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SUM,
		B_LAST,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/bmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/bmf_queue.sv =====
// Two-entry job queue between front and back ends.
// Depends on bmf_pkg for job_t.
module bmf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bmf_pkg::job_t push_job,
	input  logic          pop,
	output logic          not_empty,
	output logic          is_empty,
	output bmf_pkg::job_t head
);
	import bmf_pkg::*;

	job_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	assign not_empty = (count_q != 2'd0);
	assign is_empty  = (count_q == 2'd0);
	assign head      = slot_q[rd_q];
endmodule

// ===== rtl/bmf_front.sv =====
// Front end: takes words, writes pixels into the row store, tracks frame
// position and queues one job per due result. Depends on bmf_pkg.
module bmf_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bmf_pkg::frame_cfg_t cfg,
	input  logic                restart,
	input  logic                take,
	input  logic                command,
	input  logic [7:0]          pixel,
	output logic                we,
	output logic [$clog2(2*MAX_RADIUS+1)+$clog2(MAX_WIDTH)-1:0] waddr,
	output logic [7:0]          wdata,
	output logic                push,
	output bmf_pkg::job_t       push_job
);
	import bmf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = $clog2(2*MAX_RADIUS+1);
	localparam int PW = WIDTH_BITS + HEIGHT_BITS;

	logic [WIDTH_BITS-1:0]  wcol_q, ocol_q;
	logic [SLOT_BITS-1:0]   wslot_q, oslot_q;
	logic [HEIGHT_BITS-1:0] orow_q;
	logic [PW-1:0]          pos_q;
	logic [PW-1:0]          total, lag;
	logic                   filling, waiting, last, col_end, ocol_end;

	assign total    = PW'(cfg.width) * PW'(cfg.height);
	assign lag      = PW'(cfg.radius) * PW'(cfg.width) + PW'(cfg.radius);
	assign filling  = (pos_q < total);
	assign waiting  = (pos_q < lag);
	assign col_end  = ({1'b0, wcol_q} + 1'b1 >= {1'b0, cfg.width});
	assign ocol_end = ({1'b0, ocol_q} + 1'b1 >= {1'b0, cfg.width});
	assign last     = ({1'b0, orow_q} + 1'b1 >= {1'b0, cfg.height}) && ocol_end;

	// a flush before the image is complete is dropped outright
	assign we    = take && filling && !command;
	assign waddr = {wslot_q[SW-1:0], wcol_q[CW-1:0]};
	assign wdata = pixel;
	assign push  = take && !(filling && command) && !waiting;

	always_comb begin
		push_job      = '0;
		push_job.row  = orow_q;
		push_job.col  = ocol_q;
		push_job.slot = oslot_q;
		push_job.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcol_q  <= '0;
			wslot_q <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			oslot_q <= '0;
			pos_q   <= '0;
		end else if (restart || (push && last)) begin
			wcol_q  <= '0;
			wslot_q <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			oslot_q <= '0;
			pos_q   <= '0;
		end else begin
			if (we) begin
				if (col_end) begin
					wcol_q  <= '0;
					wslot_q <= (wslot_q + 1'b1 >= cfg.span) ? '0 : wslot_q + 1'b1;
				end else begin
					wcol_q <= wcol_q + 1'b1;
				end
			end
			if (take && !(filling && command))
				pos_q <= pos_q + 1'b1;
			if (push) begin
				if (ocol_end) begin
					ocol_q  <= '0;
					orow_q  <= orow_q + 1'b1;
					oslot_q <= (oslot_q + 1'b1 >= cfg.span) ? '0 : oslot_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/bmf_back.sv =====
// Back end: sums the window of an inner position by reading the row store one
// pixel a cycle, divides it by the window area bit-serially and holds the
// result word; a border position gives 0. Depends on bmf_pkg.
module bmf_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bmf_pkg::frame_cfg_t cfg,
	input  logic                job_valid,
	input  bmf_pkg::job_t       job,
	output logic                pop,
	output logic                reading,
	output logic                re,
	output logic [$clog2(2*MAX_RADIUS+1)+$clog2(MAX_WIDTH)-1:0] raddr,
	input  logic [7:0]          rdata,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          mean_value,
	output logic                frame_last
);
	import bmf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = $clog2(2*MAX_RADIUS+1);
	localparam int DB = $clog2(SUM_BITS + 1);

	back_state_t            state_q, state_d;
	logic [WIDTH_BITS-1:0]  col_q, col0_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic [SPAN_BITS-1:0]   i_q, j_q;
	logic [SUM_BITS-1:0]    dq_q;
	logic [AREA_BITS-1:0]   rem_q;
	logic [DB-1:0]          div_q;
	logic                   last_q, border, row_done, all_done, div_done;
	logic [AREA_BITS:0]     rem_t;
	logic [SLOT_BITS-1:0]   base_slot;

	assign border = (job.row < HEIGHT_BITS'(cfg.radius))
		|| (job.col < WIDTH_BITS'(cfg.radius))
		|| ({1'b0, job.row} + (HEIGHT_BITS+1)'(cfg.radius) >= {1'b0, cfg.height})
		|| ({1'b0, job.col} + (WIDTH_BITS+1)'(cfg.radius) >= {1'b0, cfg.width});
	assign base_slot = (job.slot >= SLOT_BITS'(cfg.radius))
		? job.slot - SLOT_BITS'(cfg.radius)
		: job.slot + SLOT_BITS'(cfg.span) - SLOT_BITS'(cfg.radius);
	assign row_done = (j_q + 1'b1 == cfg.span);
	assign all_done = row_done && (i_q + 1'b1 == cfg.span);
	assign div_done = (div_q == DB'(SUM_BITS - 1));
	assign rem_t    = {rem_q, dq_q[SUM_BITS-1]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (job_valid) state_d = border ? B_OUT : B_SUM;
			B_SUM:  if (all_done) state_d = B_LAST;
			B_LAST: state_d = B_DIV;
			B_DIV:  if (div_done) state_d = B_OUT;
			B_OUT:  if (out_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		reading   = 1'b0;
		re        = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			B_IDLE: pop = job_valid;
			B_SUM: begin
				reading = 1'b1;
				re      = 1'b1;
			end
			B_LAST: reading = 1'b1;
			B_DIV: ;
			B_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign raddr      = {slot_q[SW-1:0], col_q[CW-1:0]};
	assign mean_value = dq_q[7:0];
	assign frame_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				last_q <= job.last;
				col0_q <= job.col - WIDTH_BITS'(cfg.radius);
				col_q  <= job.col - WIDTH_BITS'(cfg.radius);
				slot_q <= base_slot;
				i_q    <= '0;
				j_q    <= '0;
				dq_q   <= '0;
				rem_q  <= '0;
				div_q  <= '0;
			end
			B_SUM: begin
				// read data is registered and arrives the cycle after its address; first read adds zero
				if (i_q != '0 || j_q != '0)
					dq_q <= dq_q + SUM_BITS'(rdata);
				if (row_done) begin
					j_q    <= '0;
					i_q    <= i_q + 1'b1;
					col_q  <= col0_q;
					slot_q <= (slot_q + 1'b1 >= cfg.span) ? '0 : slot_q + 1'b1;
				end else begin
					j_q   <= j_q + 1'b1;
					col_q <= col_q + 1'b1;
				end
			end
			B_LAST: dq_q <= dq_q + SUM_BITS'(rdata);
			B_DIV: begin
				div_q <= div_q + 1'b1;
				if (rem_t >= {1'b0, cfg.area}) begin
					rem_q <= AREA_BITS'(rem_t - {1'b0, cfg.area});
					dq_q  <= {dq_q[SUM_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_t[AREA_BITS-1:0];
					dq_q  <= {dq_q[SUM_BITS-2:0], 1'b0};
				end
			end
			B_OUT: ;
			default: ;
		endcase
	end
endmodule

// ===== rtl/box_mean_filter_running_sum_core.sv =====
// Box mean filter over a raster stream of 8-bit grey pixels.
// Depends on bmf_pkg, bmf_ram, bmf_queue, bmf_front and bmf_back.
//
// Each input word is a pixel or a flush tick; after the first
// radius*width+radius words each word yields one mean, in raster order, and
// flush ticks drive out the tail of the frame. A border position gives its 0
// with no window sum, straight from the job queue. For an inner position
// the window is summed one pixel a cycle through the single read port of the
// row store, then divided by the area bit-serially. A new word is taken only
// once the job queue is empty and the previous window has been read. The row
// store needs no clearing after reset. Register writes other than to the
// spare index restart the frame.
module box_mean_filter_running_sum_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  mean_value,
	output logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import bmf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = $clog2(2*MAX_RADIUS+1);
	localparam int AW = SW + CW;

	logic [10:0] width_q;
	logic [11:0] height_q;
	logic [2:0]  radius_q;
	logic        restart;
	frame_cfg_t  cfg;
	logic [WIDTH_BITS-1:0]  w13;
	logic [RADIUS_BITS-1:0] r4;

	logic          take, we, re, push, pop, q_valid, q_empty, reading;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	job_t          push_job, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 12'd480;
			radius_q <= 3'd3;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[2:0];
				REG_SPARE:  ;
				default:    ;
			endcase
		end
	end

	assign restart = cfg_valid && (reg_index_t'(cfg_index) != REG_SPARE);

	always_comb begin
		w13 = WIDTH_BITS'(width_q);
		r4  = RADIUS_BITS'(radius_q);
		cfg = '0;
		if (w13 == '0)
			cfg.width = WIDTH_BITS'(1);
		else if (w13 > WIDTH_BITS'(MAX_WIDTH))
			cfg.width = WIDTH_BITS'(MAX_WIDTH);
		else
			cfg.width = w13;
		cfg.height = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;
		cfg.radius = (r4 > RADIUS_BITS'(MAX_RADIUS)) ? RADIUS_BITS'(MAX_RADIUS) : r4;
		cfg.span   = {cfg.radius, 1'b1};
		cfg.area   = AREA_BITS'(cfg.span * cfg.span);
	end

	// hold new words while the job queue is not empty or a window is being read from the row store
	assign in_ready = q_empty && !reading;
	assign take     = in_valid && in_ready;

	bmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .restart(restart), .take(take),
		.command(command), .pixel(pixel), .we(we), .waddr(waddr), .wdata(wdata),
		.push(push), .push_job(push_job)
	);

	bmf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .pop(pop),
		.not_empty(q_valid), .is_empty(q_empty), .head(head)
	);

	bmf_ram #(.WIDTH(8), .DEPTH((2*MAX_RADIUS+1) << CW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	bmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .job_valid(q_valid), .job(head),
		.pop(pop), .reading(reading), .re(re), .raddr(raddr), .rdata(rdata),
		.out_valid(out_valid), .out_ready(out_ready), .mean_value(mean_value),
		.frame_last(frame_last)
	);
endmodule
